// ===== design/hcem_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, codes and sha-256 helper functions for the hmac ctr block
// no dependencies

package hcem_pkg;

    localparam int POS_BITS = 32;

    // item kinds on the output tuser
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_TAG    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNCATED = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_AUTH_FAIL = 2'd3;

    localparam logic [255:0] SHA_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] K_TAB [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] sml_sig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sml_sig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ===== design/hmac_ctr_encrypt_then_mac.sv =====
`timescale 1ns / 1ps
// top level of the hmac-sha256 counter-mode encrypt-then-mac byte stream block
// depends on hcem_pkg and hcem_sha_core

// Byte-stream cipher: keystream block n is HMAC-SHA256(key, nonce || n) and is
// xored with the data 32 bytes at a time. With decrypt_mode clear every
// plaintext byte gives one cipher byte, and the last byte is followed by 32 tag
// bytes, the HMAC of nonce || cipher. With decrypt_mode set the input is
// nonce || cipher || tag: the last 32 bytes are held in a window, plaintext
// leaves as soon as a byte drops out of the window, and the message ends with
// one status item (ok, truncated, empty cipher, auth failed). Plaintext goes
// out before the tag is checked, so a consumer drops it on a failed status.
// Key, mode and (for encryption) nonce are latched with the first byte of a
// message; registers may be rewritten only while the block is idle.
// All hashing runs on one shared SHA-256 compression unit, and the block takes
// no new byte while it works. The ipad and opad chain values are hashed once
// per message, at message start. A 32-byte keystream block costs two
// compressions and the MAC one per 64 bytes, and each data byte is sequenced
// through accept, process, xor, feed, emit and end. The last byte adds the
// padding steps, one or two compressions and the outer hash before the tag or
// the ok or auth-failed status leaves; a truncated or empty cipher skips the
// padding and hashing and goes straight to its status item.

module hmac_ctr_encrypt_then_mac import hcem_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  logic        i_s_tlast,   // in_last
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] out_byte
    output logic [3:0]  o_m_tuser,   // [1:0] item_kind, [3:2] result_status
    output logic        o_m_tlast    // out_last
);

    // register indexes
    localparam logic [2:0] REG_KEY0   = 3'd0;
    localparam logic [2:0] REG_KEY1   = 3'd1;
    localparam logic [2:0] REG_KEY2   = 3'd2;
    localparam logic [2:0] REG_KEY3   = 3'd3;
    localparam logic [2:0] REG_NONCEH = 3'd4;
    localparam logic [2:0] REG_NONCEL = 3'd5;
    localparam logic [2:0] REG_MODE   = 3'd6;

    // sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_KI    = 5'd1;   // start ipad key block
    localparam logic [4:0] S_KIW   = 5'd2;
    localparam logic [4:0] S_KO    = 5'd3;   // start opad key block
    localparam logic [4:0] S_KOW   = 5'd4;
    localparam logic [4:0] S_NF    = 5'd5;   // push nonce into mac buffer
    localparam logic [4:0] S_PROC  = 5'd6;
    localparam logic [4:0] S_KS    = 5'd7;   // keystream inner hash
    localparam logic [4:0] S_KSW   = 5'd8;
    localparam logic [4:0] S_KS2   = 5'd9;   // keystream outer hash
    localparam logic [4:0] S_KS2W  = 5'd10;
    localparam logic [4:0] S_XOR   = 5'd11;
    localparam logic [4:0] S_FEED  = 5'd12;
    localparam logic [4:0] S_MACGO = 5'd13;
    localparam logic [4:0] S_MACW  = 5'd14;
    localparam logic [4:0] S_EMIT  = 5'd15;
    localparam logic [4:0] S_END   = 5'd16;
    localparam logic [4:0] S_P80   = 5'd17;
    localparam logic [4:0] S_PZ    = 5'd18;
    localparam logic [4:0] S_PL    = 5'd19;
    localparam logic [4:0] S_OUT   = 5'd20;
    localparam logic [4:0] S_OUTW  = 5'd21;
    localparam logic [4:0] S_TAG   = 5'd22;
    localparam logic [4:0] S_STAT  = 5'd23;

    localparam logic [255:0] IPAD_FILL = {32{8'h36}};
    localparam logic [255:0] OPAD_FILL = {32{8'h5c}};
    // hmac length fields: (64 + 24) and (64 + 32) bytes, in bits
    localparam logic [63:0] KS_INNER_BITS = 64'd704;
    localparam logic [63:0] OUTER_BITS    = 64'd768;
    localparam int NONCE_BYTES = 16;
    localparam int MIN_CONTENT = 16 + 32;

    // configuration registers
    logic [255:0] r_cfg_key;
    logic [127:0] r_cfg_nonce;
    logic         r_cfg_dec;

    // message state
    logic [4:0]          r_state, n_state;
    logic [4:0]          r_ret, n_ret;
    logic [POS_BITS-1:0] r_pos, n_pos;
    logic [255:0]        r_key, n_key;
    logic                r_dec, n_dec;
    logic [127:0]        r_nonce, n_nonce;
    logic [255:0]        r_ipad, n_ipad;
    logic [255:0]        r_opad, n_opad;
    logic [255:0]        r_mac, n_mac;
    logic [255:0]        r_ks, n_ks;
    logic [255:0]        r_tag, n_tag;
    logic [255:0]        r_win, n_win;
    logic [511:0]        r_buf, n_buf;
    logic [63:0]         r_ctr, n_ctr;
    logic [4:0]          r_off, n_off;
    logic [5:0]          r_fill, n_fill;
    logic [63:0]         r_cnt, n_cnt;
    logic [63:0]         r_len, n_len;
    logic [4:0]          r_step, n_step;
    logic [7:0]          r_b, n_b;
    logic                r_last, n_last;
    logic [7:0]          r_c, n_c;
    logic [7:0]          r_e, n_e;
    logic                r_emit, n_emit;
    logic [1:0]          r_status, n_status;

    // output register
    logic       r_m_valid, n_m_valid;
    logic [7:0] r_m_byte, n_m_byte;
    logic [1:0] r_m_kind, n_m_kind;
    logic [1:0] r_m_status, n_m_status;
    logic       r_m_last, n_m_last;

    // compression unit
    logic         c_start;
    logic [255:0] c_h_in;
    logic [511:0] c_blk;
    logic         c_done;
    logic [255:0] c_h;

    logic       out_free;
    logic       in_acc;
    logic [7:0] key_byte;

    hcem_sha_core u_sha (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_start),
        .i_h     (c_h_in),
        .i_blk   (c_blk),
        .o_done  (c_done),
        .o_h     (c_h)
    );

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign in_acc      = i_s_tvalid && o_s_tready;
    assign out_free    = !r_m_valid || i_m_tready;
    assign key_byte    = r_ks[{~r_off, 3'b111} -: 8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_key   <= '0;
            r_cfg_nonce <= '0;
            r_cfg_dec   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_KEY0:   r_cfg_key[255:192] <= i_cfg_data;
                REG_KEY1:   r_cfg_key[191:128] <= i_cfg_data;
                REG_KEY2:   r_cfg_key[127:64]  <= i_cfg_data;
                REG_KEY3:   r_cfg_key[63:0]    <= i_cfg_data;
                REG_NONCEH: r_cfg_nonce[127:64] <= i_cfg_data;
                REG_NONCEL: r_cfg_nonce[63:0]   <= i_cfg_data;
                REG_MODE:   r_cfg_dec <= i_cfg_data[0];
                default:    ;   // unused index, write dropped
            endcase
        end
    end

    // compression requests, issued by the start states
    always_comb begin
        c_start = 1'b0;
        c_h_in  = r_mac;
        c_blk   = r_buf;
        unique case (r_state)
            S_KI: begin
                c_start = 1'b1;
                c_h_in  = SHA_IV;
                c_blk   = {r_key ^ IPAD_FILL, IPAD_FILL};
            end
            S_KO: begin
                c_start = 1'b1;
                c_h_in  = SHA_IV;
                c_blk   = {r_key ^ OPAD_FILL, OPAD_FILL};
            end
            S_KS: begin
                c_start = 1'b1;
                c_h_in  = r_ipad;
                c_blk   = {r_nonce, r_ctr, 8'h80, 248'd0, KS_INNER_BITS};
            end
            S_KS2: begin
                c_start = 1'b1;
                c_h_in  = r_opad;
                c_blk   = {c_h, 8'h80, 184'd0, OUTER_BITS};
            end
            S_MACGO: begin
                c_start = 1'b1;
            end
            S_OUT: begin
                c_start = 1'b1;
                c_h_in  = r_opad;
                c_blk   = {r_mac, 8'h80, 184'd0, OUTER_BITS};
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_pos    = r_pos;
        n_key    = r_key;
        n_dec    = r_dec;
        n_nonce  = r_nonce;
        n_ipad   = r_ipad;
        n_opad   = r_opad;
        n_mac    = r_mac;
        n_ks     = r_ks;
        n_tag    = r_tag;
        n_win    = r_win;
        n_buf    = r_buf;
        n_ctr    = r_ctr;
        n_off    = r_off;
        n_fill   = r_fill;
        n_cnt    = r_cnt;
        n_len    = r_len;
        n_step   = r_step;
        n_b      = r_b;
        n_last   = r_last;
        n_c      = r_c;
        n_e      = r_e;
        n_emit   = r_emit;
        n_status = r_status;

        n_m_valid  = r_m_valid && !i_m_tready;
        n_m_byte   = r_m_byte;
        n_m_kind   = r_m_kind;
        n_m_status = r_m_status;
        n_m_last   = r_m_last;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_b    = i_s_tdata;
                    n_last = i_s_tlast;
                    if (r_pos == '0) begin
                        // message start: latch key and mode, reset counters
                        n_key  = r_cfg_key;
                        n_dec  = r_cfg_dec;
                        if (!r_cfg_dec) begin
                            n_nonce = r_cfg_nonce;
                        end
                        n_cnt   = 64'd64;
                        n_ctr   = '0;
                        n_off   = '0;
                        n_fill  = '0;
                        n_win   = '0;
                        n_step  = '0;
                        n_state = S_KI;
                    end else begin
                        n_state = S_PROC;
                    end
                end
            end
            S_KI:  n_state = S_KIW;
            S_KIW: begin
                if (c_done) begin
                    n_ipad  = c_h;
                    n_mac   = c_h;
                    n_state = S_KO;
                end
            end
            S_KO:  n_state = S_KOW;
            S_KOW: begin
                if (c_done) begin
                    n_opad  = c_h;
                    n_step  = '0;
                    n_state = r_dec ? S_PROC : S_NF;
                end
            end
            S_NF: begin
                // sixteen nonce bytes never fill a block
                n_buf  = {r_buf[503:0], r_nonce[{~r_step[3:0], 3'b111} -: 8]};
                n_fill = r_fill + 6'd1;
                n_cnt  = r_cnt + 64'd1;
                n_step = r_step + 5'd1;
                if (r_step == 5'(NONCE_BYTES - 1)) begin
                    n_state = S_PROC;
                end
            end
            S_PROC: begin
                if (!r_dec) begin
                    n_emit  = 1'b1;
                    n_state = (r_off == '0) ? S_KS : S_XOR;
                end else if (r_pos < POS_BITS'(NONCE_BYTES)) begin
                    n_nonce = {r_nonce[119:0], r_b};
                    n_c     = r_b;
                    n_emit  = 1'b0;
                    n_state = S_FEED;
                end else if (r_pos < POS_BITS'(MIN_CONTENT)) begin
                    n_win   = {r_win[247:0], r_b};
                    n_state = S_END;
                end else begin
                    // oldest window byte is cipher text
                    n_c     = r_win[255:248];
                    n_win   = {r_win[247:0], r_b};
                    n_state = (r_off == '0) ? S_KS : S_XOR;
                end
            end
            S_KS:  n_state = S_KSW;
            S_KSW: begin
                if (c_done) begin
                    n_state = S_KS2;
                end
            end
            S_KS2:  n_state = S_KS2W;
            S_KS2W: begin
                if (c_done) begin
                    n_ks    = c_h;
                    n_state = S_XOR;
                end
            end
            S_XOR: begin
                if (r_dec) begin
                    n_e = r_c ^ key_byte;
                end else begin
                    n_c = r_b ^ key_byte;
                    n_e = r_b ^ key_byte;
                end
                n_emit = 1'b1;
                n_off  = r_off + 5'd1;
                if (r_off == 5'd31) begin
                    n_ctr = r_ctr + 64'd1;
                end
                n_state = S_FEED;
            end
            S_FEED: begin
                n_buf  = {r_buf[503:0], r_c};
                n_fill = r_fill + 6'd1;
                n_cnt  = r_cnt + 64'd1;
                if (r_fill == 6'd63) begin
                    n_ret   = r_emit ? S_EMIT : S_END;
                    n_state = S_MACGO;
                end else begin
                    n_state = r_emit ? S_EMIT : S_END;
                end
            end
            S_MACGO: n_state = S_MACW;
            S_MACW: begin
                if (c_done) begin
                    n_mac   = c_h;
                    n_state = r_ret;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_m_valid  = 1'b1;
                    n_m_byte   = r_e;
                    n_m_kind   = KIND_DATA;
                    n_m_status = ST_OK;
                    n_m_last   = 1'b0;
                    n_state    = S_END;
                end
            end
            S_END: begin
                if (!r_last) begin
                    n_pos   = (r_pos == '1) ? r_pos : r_pos + POS_BITS'(1);
                    n_state = S_IDLE;
                end else begin
                    n_pos = '0;
                    n_len = r_cnt << 3;
                    if (r_dec && r_pos < POS_BITS'(MIN_CONTENT - 1)) begin
                        n_status = ST_TRUNCATED;
                        n_state  = S_STAT;
                    end else if (r_dec && r_pos == POS_BITS'(MIN_CONTENT - 1)) begin
                        n_status = ST_EMPTY;
                        n_state  = S_STAT;
                    end else begin
                        n_state = S_P80;
                    end
                end
            end
            S_P80: begin
                n_buf  = {r_buf[503:0], 8'h80};
                n_fill = r_fill + 6'd1;
                if (r_fill == 6'd63) begin
                    n_ret   = S_PZ;
                    n_state = S_MACGO;
                end else begin
                    n_state = S_PZ;
                end
            end
            S_PZ: begin
                if (r_fill == 6'd56) begin
                    n_step  = '0;
                    n_state = S_PL;
                end else begin
                    n_buf  = {r_buf[503:0], 8'h00};
                    n_fill = r_fill + 6'd1;
                    if (r_fill == 6'd63) begin
                        n_ret   = S_PZ;
                        n_state = S_MACGO;
                    end
                end
            end
            S_PL: begin
                // bit length, most significant byte first, closes the block
                n_buf  = {r_buf[503:0], r_len[63:56]};
                n_len  = r_len << 8;
                n_fill = r_fill + 6'd1;
                n_step = r_step + 5'd1;
                if (r_step == 5'd7) begin
                    n_ret   = S_OUT;
                    n_state = S_MACGO;
                end
            end
            S_OUT:  n_state = S_OUTW;
            S_OUTW: begin
                if (c_done) begin
                    n_tag  = c_h;
                    n_step = '0;
                    if (r_dec) begin
                        n_status = (c_h == r_win) ? ST_OK : ST_AUTH_FAIL;
                        n_state  = S_STAT;
                    end else begin
                        n_state = S_TAG;
                    end
                end
            end
            S_TAG: begin
                if (out_free) begin
                    n_m_valid  = 1'b1;
                    n_m_byte   = r_tag[255:248];
                    n_m_kind   = KIND_TAG;
                    n_m_status = ST_OK;
                    n_m_last   = (r_step == 5'd31);
                    n_tag      = r_tag << 8;
                    n_step     = r_step + 5'd1;
                    if (r_step == 5'd31) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_STAT: begin
                if (out_free) begin
                    n_m_valid  = 1'b1;
                    n_m_byte   = 8'h00;
                    n_m_kind   = KIND_STATUS;
                    n_m_status = r_status;
                    n_m_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            r_pos     <= '0;
            r_m_valid <= 1'b0;
            r_key     <= '0;
            r_dec     <= 1'b0;
            r_nonce   <= '0;
            r_ctr     <= '0;
            r_off     <= '0;
            r_fill    <= '0;
            r_cnt     <= '0;
            r_win     <= '0;
            r_mac     <= '0;
            r_ks      <= '0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_pos     <= n_pos;
            r_m_valid <= n_m_valid;
            r_key     <= n_key;
            r_dec     <= n_dec;
            r_nonce   <= n_nonce;
            r_ctr     <= n_ctr;
            r_off     <= n_off;
            r_fill    <= n_fill;
            r_cnt     <= n_cnt;
            r_win     <= n_win;
            r_mac     <= n_mac;
            r_ks      <= n_ks;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ipad     <= n_ipad;
        r_opad     <= n_opad;
        r_tag      <= n_tag;
        r_buf      <= n_buf;
        r_len      <= n_len;
        r_step     <= n_step;
        r_b        <= n_b;
        r_last     <= n_last;
        r_c        <= n_c;
        r_e        <= n_e;
        r_emit     <= n_emit;
        r_status   <= n_status;
        r_m_byte   <= n_m_byte;
        r_m_kind   <= n_m_kind;
        r_m_status <= n_m_status;
        r_m_last   <= n_m_last;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_byte;
    assign o_m_tuser  = {r_m_status, r_m_kind};
    assign o_m_tlast  = r_m_last;

`ifndef SYNTHESIS
    // the hash unit only finishes while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_done |-> (r_state == S_KIW || r_state == S_KOW || r_state == S_KSW ||
                    r_state == S_KS2W || r_state == S_MACW || r_state == S_OUTW))
        else $error("hash unit finished outside a wait state");

    // a status item always closes the message and carries no byte
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1:0] == KIND_STATUS) |-> (o_m_tlast && o_m_tdata == 8'h00))
        else $error("status item without last flag or with data");

    // data and tag items report a clear status
    a_data_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1:0] != KIND_STATUS) |-> (o_m_tuser[3:2] == ST_OK))
        else $error("status code on a data or tag item");

    // a new request is taken only after the hash unit has gone quiet
    a_no_accept_in_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |=> !c_done)
        else $error("hash unit active while idle");
`endif

endmodule

// ===== design/hcem_sha_core.sv =====
`timescale 1ns / 1ps
// sha-256 compression unit, one round per cycle
// depends on hcem_pkg

module hcem_sha_core import hcem_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [255:0] i_h,
    input  logic [511:0] i_blk,
    output logic         o_done,
    output logic [255:0] o_h
);

    logic        r_busy;
    logic        r_fin;
    logic        r_done;
    logic [5:0]  r_t;
    logic [31:0] r_w    [16];
    logic [31:0] r_v    [8];
    logic [31:0] r_base [8];
    logic [255:0] r_h;

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] w_new;

    always_comb begin
        t1 = r_v[7] + big_sig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + K_TAB[r_t] + r_w[0];
        t2 = big_sig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        w_new = sml_sig1(r_w[14]) + r_w[9] + sml_sig0(r_w[1]) + r_w[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_t    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_t    <= '0;
            end else if (r_busy) begin
                r_t <= r_t + 6'd1;
                if (r_t == 6'd63) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            for (int i = 0; i < 8; i++) begin
                r_base[i] <= i_h[255 - 32*i -: 32];
                r_v[i]    <= i_h[255 - 32*i -: 32];
            end
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= i_blk[511 - 32*i -: 32];
            end
        end else if (r_busy) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= w_new;
        end else if (r_fin) begin
            for (int i = 0; i < 8; i++) begin
                r_h[255 - 32*i -: 32] <= r_base[i] + r_v[i];
            end
        end
    end

    assign o_done = r_done;
    assign o_h    = r_h;

endmodule
